>>> src/stt_pkg.sv
// Shared types and codes for the source text tokenizer.
// Used by stt_lexer, stt_out_buf and source_text_tokenizer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

   localparam int POSITION_BITS = 16;
   localparam int MAX_RES       = 3;

   localparam logic [3:0] CLS_IDENT   = 4'd0;
   localparam logic [3:0] CLS_TYPE    = 4'd1;
   localparam logic [3:0] CLS_BOOL    = 4'd2;
   localparam logic [3:0] CLS_NUM     = 4'd3;
   localparam logic [3:0] CLS_STR     = 4'd4;
   localparam logic [3:0] CLS_COLON   = 4'd5;
   localparam logic [3:0] CLS_SEMI    = 4'd6;
   localparam logic [3:0] CLS_COMMA   = 4'd7;
   localparam logic [3:0] CLS_ASSIGN  = 4'd8;
   localparam logic [3:0] CLS_LPAREN  = 4'd9;
   localparam logic [3:0] CLS_RPAREN  = 4'd10;
   localparam logic [3:0] CLS_UNKNOWN = 4'd11;
   localparam logic [3:0] CLS_EOF     = 4'd12;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic REC_TEXT = 1'b0;
   localparam logic REC_END  = 1'b1;

   typedef logic [POSITION_BITS-1:0] pos_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic       rec_type;
      logic [7:0] text_byte;
      logic [3:0] token_class;
      pos_type    start_line;
      pos_type    start_column;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                count;
      rsp_type [MAX_RES-1:0]     res;
   } batch_type;

endpackage

`default_nettype wire

>>> src/stt_lexer.sv
// Lexer state and single-pass decode: one source beat in, up to three records out.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_lexer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stt_pkg::req_type   item,
   input  wire logic               commit,
   output stt_pkg::batch_type      batch
);

   localparam int         POSITION_BITS = stt_pkg::POSITION_BITS;
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_WORD = 2'd1;
   localparam logic [1:0] MODE_NUM  = 2'd2;
   localparam logic [1:0] MODE_STR  = 2'd3;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   logic [1:0]               mode_ff, mode_in;
   logic                     esc_ff, esc_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] col_ff, col_in;
   logic [POSITION_BITS-1:0] tline_ff, tline_in;
   logic [POSITION_BITS-1:0] tcol_ff, tcol_in;
   logic [5:0]               hits_ff, hits_in;
   logic [2:0]               wlen_ff, wlen_in;

   logic [1:0]                             n;
   stt_pkg::rsp_type [stt_pkg::MAX_RES-1:0] res;
   logic [7:0]                             c;
   logic                                   do_close;
   logic                                   do_idle;

   function automatic logic [2:0] key_len(input int k);
      case (k)
         0:       return 3'd3;
         1:       return 3'd6;
         2:       return 3'd4;
         3:       return 3'd4;
         4:       return 3'd4;
         default: return 3'd5;
      endcase
   endfunction

   function automatic logic [47:0] key_text(input int k);
      case (k)
         0:       return 48'("int");
         1:       return 48'("string");
         2:       return 48'("bool");
         3:       return 48'("auto");
         4:       return 48'("true");
         default: return 48'("false");
      endcase
   endfunction

   function automatic logic [5:0] next_hits(input logic [5:0] hits, input logic [2:0] len,
                                            input logic [7:0] ch);
      logic [5:0]  h;
      logic [2:0]  pos;
      logic [47:0] txt;
      h = hits;
      for (int k = 0; k < 6; k++) begin
         txt = key_text(k);
         pos = key_len(k) - len - 3'd1;
         if (len >= key_len(k) || txt[8*pos +: 8] != ch) begin
            h[k] = 1'b0;
         end
      end
      return h;
   endfunction

   function automatic logic [3:0] word_class(input logic [5:0] hits, input logic [2:0] len);
      logic [3:0] cls;
      logic       found;
      cls   = stt_pkg::CLS_IDENT;
      found = 1'b0;
      for (int k = 0; k < 6; k++) begin
         if (!found && hits[k] && len == key_len(k)) begin
            found = 1'b1;
            cls   = (k < 4) ? stt_pkg::CLS_TYPE : stt_pkg::CLS_BOOL;
         end
      end
      return cls;
   endfunction

   function automatic logic is_alpha(input logic [7:0] ch);
      return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] ch);
      return ch == " " || (ch >= 8'd9 && ch <= 8'd13);
   endfunction

   function automatic stt_pkg::rsp_type mk_text(input logic [7:0] ch);
      stt_pkg::rsp_type r;
      r           = '0;
      r.rec_type  = stt_pkg::REC_TEXT;
      r.text_byte = ch;
      return r;
   endfunction

   function automatic stt_pkg::rsp_type mk_end(input logic [3:0] cls,
                                               input logic [POSITION_BITS-1:0] ln,
                                               input logic [POSITION_BITS-1:0] col);
      stt_pkg::rsp_type r;
      r              = '0;
      r.rec_type     = stt_pkg::REC_END;
      r.token_class  = cls;
      r.start_line   = ln;
      r.start_column = col;
      return r;
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      hits_in  = hits_ff;
      wlen_in  = wlen_ff;
      n        = 2'd0;
      res      = '0;
      c        = item.char_in;
      do_close = 1'b0;
      do_idle  = 1'b0;

      if (item.kind == stt_pkg::KIND_END) begin
         do_close = 1'b1;
      end else begin
         case (mode_ff)
            MODE_STR: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  if (c == 8'd0) begin
                     res[n] = mk_text(CH_BSLASH);
                     n      = n + 2'd1;
                     res[n] = mk_text(8'd0);
                     n      = n + 2'd1;
                  end else if (c == "n") begin
                     res[n] = mk_text(CH_NL);
                     n      = n + 2'd1;
                  end else if (c == "t") begin
                     res[n] = mk_text(CH_TAB);
                     n      = n + 2'd1;
                  end else begin
                     res[n] = mk_text(c);
                     n      = n + 2'd1;
                  end
               end else if (c == CH_QUOTE) begin
                  res[n]  = mk_end(stt_pkg::CLS_STR, tline_ff, tcol_ff);
                  n       = n + 2'd1;
                  mode_in = MODE_IDLE;
               end else if (c == CH_BSLASH) begin
                  esc_in = 1'b1;
               end else begin
                  res[n] = mk_text(c);
                  n      = n + 2'd1;
               end
            end
            MODE_WORD: begin
               if (is_alpha(c) || is_digit(c) || c == "_") begin
                  hits_in = next_hits(hits_ff, wlen_ff, c);
                  if (wlen_ff != 3'd7) begin
                     wlen_in = wlen_ff + 3'd1;
                  end
                  res[n] = mk_text(c);
                  n      = n + 2'd1;
               end else begin
                  do_close = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_NUM: begin
               if (is_digit(c)) begin
                  res[n] = mk_text(c);
                  n      = n + 2'd1;
               end else begin
                  do_close = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase
      end

      if (do_close) begin
         case (mode_ff)
            MODE_WORD: begin
               res[n] = mk_end(word_class(hits_ff, wlen_ff), tline_ff, tcol_ff);
               n      = n + 2'd1;
            end
            MODE_NUM: begin
               res[n] = mk_end(stt_pkg::CLS_NUM, tline_ff, tcol_ff);
               n      = n + 2'd1;
            end
            MODE_STR: begin
               if (esc_ff) begin
                  res[n] = mk_text(CH_BSLASH);
                  n      = n + 2'd1;
               end
               res[n] = mk_end(stt_pkg::CLS_STR, tline_ff, tcol_ff);
               n      = n + 2'd1;
            end
            default: begin
            end
         endcase
         mode_in = MODE_IDLE;
         esc_in  = 1'b0;
      end

      if (do_idle && !is_space(c)) begin
         tline_in = line_ff;
         tcol_in  = col_ff;
         if (is_alpha(c) || c == "_") begin
            mode_in = MODE_WORD;
            hits_in = next_hits(6'h3F, 3'd0, c);
            wlen_in = 3'd1;
            res[n]  = mk_text(c);
            n       = n + 2'd1;
         end else if (is_digit(c)) begin
            mode_in = MODE_NUM;
            res[n]  = mk_text(c);
            n       = n + 2'd1;
         end else if (c == CH_QUOTE) begin
            mode_in = MODE_STR;
            esc_in  = 1'b0;
         end else begin
            res[n] = mk_text(c);
            n      = n + 2'd1;
            case (c)
               ":":     res[n] = mk_end(stt_pkg::CLS_COLON, line_ff, col_ff);
               ";":     res[n] = mk_end(stt_pkg::CLS_SEMI, line_ff, col_ff);
               ",":     res[n] = mk_end(stt_pkg::CLS_COMMA, line_ff, col_ff);
               "=":     res[n] = mk_end(stt_pkg::CLS_ASSIGN, line_ff, col_ff);
               "(":     res[n] = mk_end(stt_pkg::CLS_LPAREN, line_ff, col_ff);
               ")":     res[n] = mk_end(stt_pkg::CLS_RPAREN, line_ff, col_ff);
               default: res[n] = mk_end(stt_pkg::CLS_UNKNOWN, line_ff, col_ff);
            endcase
            n = n + 2'd1;
         end
      end

      if (item.kind == stt_pkg::KIND_END) begin
         res[n]   = mk_end(stt_pkg::CLS_EOF, line_ff, col_ff);
         n        = n + 2'd1;
         mode_in  = MODE_IDLE;
         esc_in   = 1'b0;
         line_in  = POSITION_BITS'(1);
         col_in   = POSITION_BITS'(1);
         tline_in = POSITION_BITS'(1);
         tcol_in  = POSITION_BITS'(1);
         hits_in  = 6'h3F;
         wlen_in  = 3'd0;
      end else if (c == CH_NL) begin
         if (line_ff != '1) begin
            line_in = line_ff + POSITION_BITS'(1);
         end
         col_in = POSITION_BITS'(1);
      end else if (col_ff != '1) begin
         col_in = col_ff + POSITION_BITS'(1);
      end

      if (n != 2'd0) begin
         res[n - 2'd1].last = 1'b1;
      end

      batch.count = n;
      batch.res   = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         esc_ff   <= 1'b0;
         line_ff  <= POSITION_BITS'(1);
         col_ff   <= POSITION_BITS'(1);
         tline_ff <= POSITION_BITS'(1);
         tcol_ff  <= POSITION_BITS'(1);
         hits_ff  <= 6'h3F;
         wlen_ff  <= 3'd0;
      end else if (commit) begin
         mode_ff  <= mode_in;
         esc_ff   <= esc_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         hits_ff  <= hits_in;
         wlen_ff  <= wlen_in;
      end
   end

endmodule

`default_nettype wire

>>> src/stt_out_buf.sv
// Result register: holds the records of one source beat and hands them out one per beat.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_out_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire stt_pkg::batch_type  batch,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output stt_pkg::rsp_type         rsp_data
);

   stt_pkg::rsp_type [stt_pkg::MAX_RES-1:0] slot_ff, slot_in;
   logic [1:0]                             rem_ff, rem_in;
   logic [1:0]                             idx_ff, idx_in;
   logic                                   pop;

   assign rsp_valid = rem_ff != 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign can_load  = (rem_ff == 2'd0) || (rem_ff == 2'd1 && rsp_ready);

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_data = slot_ff[0];
         2'd1:    rsp_data = slot_ff[1];
         2'd2:    rsp_data = slot_ff[2];
         default: rsp_data = slot_ff[0];
      endcase
   end

   always_comb begin
      slot_in = slot_ff;
      rem_in  = rem_ff;
      idx_in  = idx_ff;
      if (load) begin
         slot_in = batch.res;
         rem_in  = batch.count;
         idx_in  = 2'd0;
      end else if (pop) begin
         rem_in = rem_ff - 2'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         rem_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> src/source_text_tokenizer.sv
// Top level of the source text tokenizer: input register, lexer, result register.
// Depends on stt_pkg, stt_lexer and stt_out_buf.
//
//   port group   dir  payload               role
//   req_*        in   stt_pkg::req_type     source byte or end-of-source beat
//   rsp_*        out  stt_pkg::rsp_type     token text byte or token end record
//
// One source beat a cycle when each beat yields at most one record and rsp_ready
// is high; a beat that yields two or three records holds the next beat in the
// input register until its last record exits the single-ported result register.
// Beats that yield nothing are consumed without waiting on the result register.
// Synchronous reset returns the lexer to idle at line 1, column 1.
// A stall on rsp backs up through the result register and the input register.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire stt_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output stt_pkg::rsp_type       rsp_data
);

   logic               in_vld_ff, in_vld_in;
   stt_pkg::req_type   in_item_ff, in_item_in;
   stt_pkg::batch_type batch;
   logic               can_load;
   logic               consume;
   logic               load;

   assign consume   = in_vld_ff && (batch.count == 2'd0 || can_load);
   assign load      = consume && batch.count != 2'd0;
   assign req_ready = !in_vld_ff || consume;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_item_in = in_item_ff;
      if (req_valid && req_ready) begin
         in_vld_in  = 1'b1;
         in_item_in = req_data;
      end else if (consume) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   stt_lexer u_lexer (
      .clock (clock),
      .reset (reset),
      .item  (in_item_ff),
      .commit(consume),
      .batch (batch)
   );

   stt_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .batch    (batch),
      .can_load (can_load),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rec_type == stt_pkg::REC_END
         && rsp_data.token_class == stt_pkg::CLS_EOF |-> rsp_data.last)
      else $error("EOF record not marked last");

   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid)
      else $error("records of a beat lost after a non-final record");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !consume |=> in_vld_ff && $stable(in_item_ff))
      else $error("held source beat dropped or changed");

endmodule

`default_nettype wire

>>> dv/source_text_tokenizer_tb.sv
// Self-checking testbench for source_text_tokenizer: random and directed source beats,
// a scoreboard class that predicts token records, random idling on both channels.
// Depends on stt_pkg and the source_text_tokenizer RTL.
`timescale 1ns / 1ps

module source_text_tokenizer_tb;

   localparam int          POSITION_BITS = stt_pkg::POSITION_BITS;
   localparam int unsigned POS_MAX       = (32'd1 << POSITION_BITS) - 1;
   localparam int          STALL_LIMIT   = 1000;
   localparam int          RANDOM_BEATS  = 270;
   localparam logic [7:0]  CH_TAB        = 8'h09;
   localparam logic [7:0]  CH_NL         = 8'h0A;
   localparam logic [7:0]  CH_QUOTE      = 8'h22;
   localparam logic [7:0]  CH_BSLASH     = 8'h5C;

   typedef enum logic [1:0] {LEX_IDLE, LEX_WORD, LEX_NUM, LEX_STR} lex_mode_e;

   class token_scoreboard;
      stt_pkg::rsp_type pending_records[$];
      lex_mode_e   mode;
      bit          escape_open;
      int unsigned line_no, column_no, tok_line, tok_column;
      bit [5:0]    key_hits;
      int          word_len;
      string       keyword[6];
      int          errors;

      function new();
         keyword = '{"int", "string", "bool", "auto", "true", "false"};
         errors  = 0;
         restart();
      endfunction

      function void restart();
         mode        = LEX_IDLE;
         escape_open = 1'b0;
         line_no     = 1;
         column_no   = 1;
         tok_line    = 1;
         tok_column  = 1;
         key_hits    = '1;
         word_len    = 0;
      endfunction

      function bit is_letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == " " || (c >= 8'd9 && c <= 8'd13);
      endfunction

      function void push_record(logic rec, logic [7:0] ch, logic [3:0] cls,
                                int unsigned ln, int unsigned col);
         stt_pkg::rsp_type r;
         r              = '0;
         r.rec_type     = rec;
         r.text_byte    = ch;
         r.token_class  = cls;
         r.start_line   = stt_pkg::pos_type'(ln & POS_MAX);
         r.start_column = stt_pkg::pos_type'(col & POS_MAX);
         pending_records.insert(pending_records.size(), r);
      endfunction

      function void push_text(logic [7:0] c);
         push_record(stt_pkg::REC_TEXT, c, stt_pkg::CLS_IDENT, 0, 0);
      endfunction

      function void advance(logic [7:0] c);
         if (c == CH_NL) begin
            if (line_no < POS_MAX) line_no++;
            column_no = 1;
         end else if (column_no < POS_MAX) begin
            column_no++;
         end
      endfunction

      function void word_char(logic [7:0] c);
         for (int k = 0; k < 6; k++) begin
            if (word_len >= keyword[k].len() || keyword[k][word_len] != c) key_hits[k] = 1'b0;
         end
         if (word_len < 7) word_len++;
         push_text(c);
         advance(c);
      endfunction

      function void close_token();
         logic [3:0] cls;
         cls = stt_pkg::CLS_IDENT;
         case (mode)
            LEX_WORD: begin
               for (int k = 0; k < 6; k++) begin
                  if (key_hits[k] && word_len == keyword[k].len()) begin
                     cls = (k < 4) ? stt_pkg::CLS_TYPE : stt_pkg::CLS_BOOL;
                     break;
                  end
               end
            end
            LEX_NUM: cls = stt_pkg::CLS_NUM;
            LEX_STR: begin
               if (escape_open) push_text(CH_BSLASH);
               cls = stt_pkg::CLS_STR;
            end
            default: return;
         endcase
         push_record(stt_pkg::REC_END, 8'h00, cls, tok_line, tok_column);
         mode        = LEX_IDLE;
         escape_open = 1'b0;
      endfunction

      function void idle_char(logic [7:0] c);
         logic [3:0] cls;
         if (is_blank(c)) begin
            advance(c);
            return;
         end
         tok_line   = line_no;
         tok_column = column_no;
         if (is_letter(c) || c == "_") begin
            mode     = LEX_WORD;
            key_hits = '1;
            word_len = 0;
            word_char(c);
         end else if (is_digit(c)) begin
            mode = LEX_NUM;
            push_text(c);
            advance(c);
         end else if (c == CH_QUOTE) begin
            mode        = LEX_STR;
            escape_open = 1'b0;
            advance(c);
         end else begin
            case (c)
               ":":     cls = stt_pkg::CLS_COLON;
               ";":     cls = stt_pkg::CLS_SEMI;
               ",":     cls = stt_pkg::CLS_COMMA;
               "=":     cls = stt_pkg::CLS_ASSIGN;
               "(":     cls = stt_pkg::CLS_LPAREN;
               ")":     cls = stt_pkg::CLS_RPAREN;
               default: cls = stt_pkg::CLS_UNKNOWN;
            endcase
            push_text(c);
            push_record(stt_pkg::REC_END, 8'h00, cls, line_no, column_no);
            advance(c);
         end
      endfunction

      function void string_char(logic [7:0] c);
         if (escape_open) begin
            escape_open = 1'b0;
            if (c == 8'h00) begin
               push_text(CH_BSLASH);
               push_text(8'h00);
            end else if (c == "n") begin
               push_text(CH_NL);
            end else if (c == "t") begin
               push_text(CH_TAB);
            end else begin
               push_text(c);
            end
         end else if (c == CH_QUOTE) begin
            close_token();
         end else if (c == CH_BSLASH) begin
            escape_open = 1'b1;
         end else begin
            push_text(c);
         end
         advance(c);
      endfunction

      function void take_source_beat(stt_pkg::req_type b);
         int mark;
         mark = pending_records.size();
         if (b.kind == stt_pkg::KIND_END) begin
            close_token();
            push_record(stt_pkg::REC_END, 8'h00, stt_pkg::CLS_EOF, line_no, column_no);
            restart();
         end else begin
            case (mode)
               LEX_STR: string_char(b.char_in);
               LEX_WORD: begin
                  if (is_letter(b.char_in) || is_digit(b.char_in) || b.char_in == "_") begin
                     word_char(b.char_in);
                  end else begin
                     close_token();
                     idle_char(b.char_in);
                  end
               end
               LEX_NUM: begin
                  if (is_digit(b.char_in)) begin
                     push_text(b.char_in);
                     advance(b.char_in);
                  end else begin
                     close_token();
                     idle_char(b.char_in);
                  end
               end
               default: idle_char(b.char_in);
            endcase
         end
         if (pending_records.size() > mark)
            pending_records[pending_records.size() - 1].last = 1'b1;
      endfunction

      function void report(string what, stt_pkg::rsp_type want, stt_pkg::rsp_type got);
         errors++;
         if (errors <= 10) begin
            $display("%0t %s: exp rec=%0d byte=%02h cls=%0d line=%0d col=%0d last=%0d",
                     $time, what, want.rec_type, want.text_byte, want.token_class,
                     want.start_line, want.start_column, want.last);
            $display("%0t %s: got rec=%0d byte=%02h cls=%0d line=%0d col=%0d last=%0d",
                     $time, what, got.rec_type, got.text_byte, got.token_class,
                     got.start_line, got.start_column, got.last);
         end
      endfunction

      function void check_record(stt_pkg::rsp_type got);
         stt_pkg::rsp_type want;
         if (pending_records.size() == 0) begin
            report("unexpected record", '0, got);
            return;
         end
         want = pending_records.pop_front();
         if (got.rec_type !== want.rec_type || got.text_byte !== want.text_byte ||
             got.token_class !== want.token_class || got.start_line !== want.start_line ||
             got.start_column !== want.start_column || got.last !== want.last)
            report("record mismatch", want, got);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   stt_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   stt_pkg::rsp_type rsp_data;

   token_scoreboard  sb = new();
   stt_pkg::req_type source_beats[$];
   int               beats_sent   = 0;
   int               send_calm    = 0;
   int               take_calm    = 0;
   int               quiet_cycles = 0;
   bit               no_gaps      = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   source_text_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic void queue_byte(logic [7:0] c);
      stt_pkg::req_type b;
      b.kind    = stt_pkg::KIND_BYTE;
      b.char_in = c;
      source_beats.insert(source_beats.size(), b);
   endfunction

   function automatic void queue_text(string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
   endfunction

   function automatic void queue_end();
      stt_pkg::req_type b;
      b.kind    = stt_pkg::KIND_END;
      b.char_in = 8'($urandom_range(0, 255));
      source_beats.insert(source_beats.size(), b);
   endfunction

   function automatic logic [7:0] rand_word_char(bit first);
      int r;
      r = $urandom_range(0, first ? 52 : 62);
      if (r < 26) return 8'(8'h61 + r);
      if (r < 52) return 8'(8'h41 + r - 26);
      if (r == 52) return 8'h5F;
      return 8'(8'h30 + r - 53);
   endfunction

   function automatic void queue_word();
      int    pick, n;
      string w;
      pick = $urandom_range(0, 5);
      if (pick < 2) begin
         queue_text(sb.keyword[$urandom_range(0, 5)]);
      end else if (pick == 2) begin
         // keyword prefixes and keywords with a tail
         w = sb.keyword[$urandom_range(0, 5)];
         n = $urandom_range(1, w.len());
         for (int i = 0; i < n; i++) queue_byte(w[i]);
         if ($urandom_range(0, 1)) queue_byte(rand_word_char(1'b0));
      end else begin
         n = $urandom_range(1, 9);
         queue_byte(rand_word_char(1'b1));
         repeat (n - 1) queue_byte(rand_word_char(1'b0));
      end
   endfunction

   function automatic logic [7:0] escape_char();
      case ($urandom_range(0, 6))
         0:       return "n";
         1:       return "t";
         2:       return CH_QUOTE;
         3:       return CH_BSLASH;
         4:       return "q";
         5:       return 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void queue_string();
      int         n, r;
      logic [7:0] c;
      queue_byte(CH_QUOTE);
      n = $urandom_range(0, 8);
      repeat (n) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            c = 8'($urandom_range(32, 126));
            queue_byte((c == CH_QUOTE || c == CH_BSLASH) ? 8'h78 : c);
         end else if (r == 6) begin
            queue_byte(8'($urandom_range(0, 255)));
         end else if (r < 9) begin
            queue_byte(CH_BSLASH);
            queue_byte(escape_char());
         end else begin
            queue_byte(CH_NL);
         end
      end
      r = $urandom_range(0, 19);
      if (r < 17) begin
         queue_byte(CH_QUOTE);
      end else if (r < 19) begin
         queue_byte(CH_BSLASH);
         queue_end();
      end else begin
         queue_end();
      end
   endfunction

   function automatic void queue_fragment();
      int    sel, r;
      string symbols;
      symbols = ":;,=()";
      sel     = $urandom_range(0, 99);
      if (sel < 30) begin
         queue_word();
      end else if (sel < 42) begin
         repeat ($urandom_range(1, 5)) queue_byte(8'(8'h30 + $urandom_range(0, 9)));
      end else if (sel < 57) begin
         queue_string();
      end else if (sel < 72) begin
         queue_byte(symbols[$urandom_range(0, 5)]);
      end else if (sel < 88) begin
         r = $urandom_range(0, 5);
         queue_byte(r == 5 ? 8'h20 : 8'(CH_TAB + r));
      end else if (sel < 96) begin
         queue_byte(8'($urandom_range(0, 255)));
      end else begin
         queue_end();
      end
   endfunction

   task automatic send_beat(input stt_pkg::req_type b);
      int gap;
      gap = no_gaps ? 0 : draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drive_queued();
      while (source_beats.size() != 0) begin
         send_beat(source_beats.pop_front());
         beats_sent++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.take_source_beat(req_data);
         if (rsp_valid && rsp_ready) sb.check_record(rsp_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : take_results
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait(take_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // symbols, odd bytes, escapes, backslash before zero, backslash at end of source,
      // sent back to back
      no_gaps = 1'b1;
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_text(":;,=()x9 auto false");
      queue_byte(CH_QUOTE);
      queue_byte(CH_BSLASH);
      queue_text("n");
      queue_byte(CH_BSLASH);
      queue_text("t");
      queue_byte(CH_BSLASH);
      queue_byte(CH_QUOTE);
      queue_byte(CH_BSLASH);
      queue_byte(CH_BSLASH);
      queue_byte(CH_BSLASH);
      queue_text("q");
      queue_byte(CH_BSLASH);
      queue_byte(8'h00);
      queue_byte(CH_QUOTE);
      queue_end();
      queue_byte(CH_QUOTE);
      queue_text("z");
      queue_byte(CH_BSLASH);
      queue_end();
      drive_queued();
      no_gaps = 1'b0;

      beats_sent = 0;
      while (beats_sent < RANDOM_BEATS) begin
         queue_fragment();
         drive_queued();
      end
      queue_end();
      drive_queued();
      req_valid <= 1'b0;

      do @(negedge clock); while (sb.pending_records.size() != 0);
      repeat (10) @(posedge clock);
      if (sb.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
